@@ hdl/template_token_scanner_defines.svh @@
// assertion macros for the template token scanner
`ifndef TEMPLATE_TOKEN_SCANNER_DEFINES_SVH
`define TEMPLATE_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication
`define TTS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tts_pkg.sv @@
// types, constants and helpers shared by the template token scanner
`default_nettype none
package tts_pkg;

    localparam int TTS_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [0:0] CFG_WS_TOKENS    = 1'b0;
    localparam logic [0:0] CFG_BLOCK_TOKENS = 1'b1;

    typedef enum logic [2:0] {
        KIND_TEXT  = 3'd0,
        KIND_WS    = 3'd1,
        KIND_OPEN  = 3'd2,
        KIND_CLOSE = 3'd3,
        KIND_HASH  = 3'd4,
        KIND_SLASH = 3'd5,
        KIND_END   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_TEXT = 2'd1,
        RUN_WS   = 2'd2
    } run_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_out;
        logic        token_start;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } result_t;

    // up to two results from one word, in order
    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } push_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage
`default_nettype wire

@@ hdl/template_token_scanner.sv @@
// each word is registered at the input, then the results it yields are written to the result queue, in order
// the scanner takes one word a cycle while the queue has room; a word giving two results
// (held byte plus end) hands them out one at a time through the single-read result queue
// the queue of QUEUE_DEPTH entries takes words while at least two slots are free
// reset (rst_n low, asynchronous): queue empty, nothing held, line 1, column 0, modes off
`default_nettype none
`include "template_token_scanner_defines.svh"
module template_token_scanner #(
    parameter int QUEUE_DEPTH = tts_pkg::TTS_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [0:0]    cfg_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    ch,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         kind,
    output logic [7:0]         char_out,
    output logic               token_start,
    output logic [15:0]        line,
    output logic [15:0]        column,
    output logic               last
);
    import tts_pkg::*;

    push_t                        push;
    logic                         room;
    result_t                      out_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

    tts_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .room      (room),
        .push      (push)
    );

    tts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .level     (level)
    );

    assign kind        = out_data.kind;
    assign char_out    = out_data.char_out;
    assign token_start = out_data.token_start;
    assign line        = out_data.line;
    assign column      = out_data.column;
    assign last        = out_data.last;

    `TTS_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "result queue overflow")
    `TTS_ASSERT_NOW(a_end_last, clk, rst_n, push.b_valid, push.b.last && !(push.a_valid && push.a.last), "end result not final")
    `TTS_ASSERT_NOW(a_end_shape, clk, rst_n, out_valid && out_data.kind == KIND_END, token_start && last && char_out == CH_NUL, "malformed end result")
    `TTS_ASSERT_NEXT(a_stall_hold, clk, rst_n, in_stall, in_stall || push.a_valid || push.b_valid || room, "stalled word dropped")

endmodule
`default_nettype wire

@@ hdl/tts_scan.sv @@
// input register, scanner state and per-word classification
`default_nettype none
module tts_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [0:0]    cfg_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    ch,
    input  wire logic          room,
    output tts_pkg::push_t     push
);
    import tts_pkg::*;

    logic        ws_on_reg, block_on_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  ch_reg;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    run_t        run_reg, run_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] column_reg, column_next;

    logic        fire, pair;
    logic [15:0] line_adv, column_adv, column_pair;
    result_t     res_a, res_b;
    run_t        run_a;

    assign fire     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign pair     = held_valid_reg && (held_byte_reg == CH_OPEN || held_byte_reg == CH_CLOSE)
                      && (ch_reg == held_byte_reg);

    assign line_adv    = (held_byte_reg == CH_NL) ? sat_inc(line_reg) : line_reg;
    assign column_adv  = (held_byte_reg == CH_NL) ? 16'd0 : sat_inc(column_reg);
    assign column_pair = sat_inc(sat_inc(column_reg));

    // result for the held byte
    always_comb
    begin
        res_a.char_out    = held_byte_reg;
        res_a.line        = line_reg;
        res_a.column      = column_reg;
        res_a.last        = pair || (ch_reg != CH_NUL);
        res_a.kind        = KIND_TEXT;
        res_a.token_start = 1'b1;
        run_a             = RUN_NONE;
        if (pair)
        begin
            res_a.kind = (held_byte_reg == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
        end
        else if (ws_on_reg && is_ws(held_byte_reg))
        begin
            res_a.kind        = KIND_WS;
            res_a.token_start = (run_reg != RUN_WS);
            run_a             = RUN_WS;
        end
        else if (block_on_reg && held_byte_reg == CH_HASH)
        begin
            res_a.kind = KIND_HASH;
        end
        else if (block_on_reg && held_byte_reg == CH_SLASH)
        begin
            res_a.kind = KIND_SLASH;
        end
        else
        begin
            res_a.token_start = (run_reg != RUN_TEXT);
            run_a             = RUN_TEXT;
        end
    end

    // end marker
    always_comb
    begin
        res_b.kind        = KIND_END;
        res_b.char_out    = CH_NUL;
        res_b.token_start = 1'b1;
        res_b.last        = 1'b1;
        res_b.line        = held_valid_reg ? line_adv : line_reg;
        res_b.column      = held_valid_reg ? column_adv : column_reg;
    end

    always_comb
    begin
        push.a_valid    = fire && held_valid_reg;
        push.a          = res_a;
        push.b_valid    = fire && !pair && (ch_reg == CH_NUL);
        push.b          = res_b;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        run_next        = run_reg;
        line_next       = line_reg;
        column_next     = column_reg;
        if (fire)
        begin
            if (pair)
            begin
                held_valid_next = 1'b0;
                run_next        = RUN_NONE;
                column_next     = column_pair;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    run_next    = run_a;
                    line_next   = line_adv;
                    column_next = column_adv;
                end
                if (ch_reg == CH_NUL)
                begin
                    held_valid_next = 1'b0;
                    run_next        = RUN_NONE;
                    line_next       = 16'd1;
                    column_next     = 16'd0;
                end
                else
                begin
                    held_valid_next = 1'b1;
                    held_byte_next  = ch_reg;
                end
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_on_reg      <= 1'b0;
            block_on_reg   <= 1'b0;
            in_valid_reg   <= 1'b0;
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            run_reg        <= RUN_NONE;
            line_reg       <= 16'd1;
            column_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WS_TOKENS:    ws_on_reg    <= cfg_data[0];
                    CFG_BLOCK_TOKENS: block_on_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            in_valid_reg   <= in_valid_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            run_reg        <= run_next;
            line_reg       <= line_next;
            column_reg     <= column_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg <= ch;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tts_queue.sv @@
// result queue taking up to two results a cycle and giving one while out_stall is low
`default_nettype none
module tts_queue #(
    parameter int DEPTH = tts_pkg::TTS_QUEUE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tts_pkg::push_t           push,
    output logic                          room,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output tts_pkg::result_t              out_data,
    output logic [$clog2(DEPTH+1)-1:0]    level
);
    import tts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    result_t        mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr_inc, wr_ptr_inc2;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           pop;
    logic [1:0]     n_push;

    assign wr_ptr_inc  = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_ptr_inc2 = (wr_ptr_inc == LAST_SLOT) ? '0 : wr_ptr_inc + 1'b1;
    assign n_push      = {1'b0, push.a_valid} + {1'b0, push.b_valid};
    assign pop         = out_valid && !out_stall;
    assign out_valid   = (count_reg != '0);
    assign out_data    = mem[rd_ptr_reg];
    assign room        = (count_reg <= CW'(DEPTH - 2));
    assign level       = count_reg;

    always_comb
    begin
        case (n_push)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = wr_ptr_inc2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(n_push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.a_valid)
        begin
            mem[wr_ptr_reg] <= push.a;
            if (push.b_valid)
            begin
                mem[wr_ptr_inc] <= push.b;
            end
        end
        else if (push.b_valid)
        begin
            mem[wr_ptr_reg] <= push.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ sim/template_token_scanner_tb.sv @@
// self-checking testbench for the template token scanner
`timescale 1ns / 1ps
module template_token_scanner_tb;
    import tts_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_op_t;

    typedef struct {
        row_op_t    op;
        logic [0:0] idx;
        logic       val;
        logic [7:0] ch;
        logic       fixed;
        result_t    want;
    } script_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = 1'b0;
    logic [0:0]  cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  char_out;
    logic        token_start;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;

    // scanner state as predicted
    logic [7:0]  held_ch;
    logic        held_on;
    run_t        open_run;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic        ws_mode;
    logic        blk_mode;

    result_t     pending_tokens[$];
    script_row_t script[$];
    int          errors = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;

    template_token_scanner i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .char_out    (char_out),
        .token_start (token_start),
        .line        (line),
        .column      (column),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void advance_pos(input logic [7:0] c);
        if (c == CH_NL)
        begin
            if (cur_line != 16'hFFFF)
                cur_line = cur_line + 16'd1;
            cur_col = 16'd0;
        end
        else if (cur_col != 16'hFFFF)
        begin
            cur_col = cur_col + 16'd1;
        end
    endfunction

    function automatic void push_token(input kind_t k, input logic [7:0] c, input logic first);
        result_t r;
        r.kind        = k;
        r.char_out    = c;
        r.token_start = first;
        r.line        = cur_line;
        r.column      = cur_col;
        r.last        = 1'b0;
        pending_tokens.push_back(r);
    endfunction

    function automatic void reset_scanner_model();
        held_ch  = 8'h00;
        held_on  = 1'b0;
        open_run = RUN_NONE;
        cur_line = 16'd1;
        cur_col  = 16'd0;
        ws_mode  = 1'b0;
        blk_mode = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        int         prior_count;
        logic [7:0] h;
        prior_count = pending_tokens.size();
        if (held_on)
        begin
            h = held_ch;
            held_on = 1'b0;
            if ((h == CH_OPEN || h == CH_CLOSE) && c == h)
            begin
                if (h == CH_OPEN)
                    push_token(KIND_OPEN, h, 1'b1);
                else
                    push_token(KIND_CLOSE, h, 1'b1);
                advance_pos(h);
                advance_pos(c);
                open_run = RUN_NONE;
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
                return;
            end
            if (ws_mode && blank_byte(h))
            begin
                push_token(KIND_WS, h, open_run != RUN_WS);
                open_run = RUN_WS;
            end
            else if (blk_mode && h == CH_HASH)
            begin
                push_token(KIND_HASH, h, 1'b1);
                open_run = RUN_NONE;
            end
            else if (blk_mode && h == CH_SLASH)
            begin
                push_token(KIND_SLASH, h, 1'b1);
                open_run = RUN_NONE;
            end
            else
            begin
                push_token(KIND_TEXT, h, open_run != RUN_TEXT);
                open_run = RUN_TEXT;
            end
            advance_pos(h);
        end
        if (c == CH_NUL)
        begin
            push_token(KIND_END, 8'h00, 1'b1);
            cur_line = 16'd1;
            cur_col  = 16'd0;
            open_run = RUN_NONE;
        end
        else
        begin
            held_ch = c;
            held_on = 1'b1;
        end
        if (pending_tokens.size() > prior_count)
            pending_tokens[pending_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_token();
        result_t want;
        if (pending_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: result expected none got kind %h char %h", $time, kind, char_out);
            return;
        end
        want = pending_tokens.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("char_out", 16'(want.char_out), 16'(char_out));
        check_field("token_start", 16'(want.token_start), 16'(token_start));
        check_field("line", want.line, line);
        check_field("column", want.column, column);
        check_field("last", 16'(want.last), 16'(last));
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        script_row_t r;
        r.op    = ROW_BYTE;
        r.idx   = 1'b0;
        r.val   = 1'b0;
        r.ch    = c;
        r.fixed = 1'b0;
        r.want  = '0;
        script.push_back(r);
    endfunction

    function automatic void put_typed(input logic [7:0] c, input kind_t k,
                                      input logic [15:0] ln, input logic [15:0] col);
        script_row_t r;
        r.op    = ROW_BYTE;
        r.idx   = 1'b0;
        r.val   = 1'b0;
        r.ch    = c;
        r.fixed = 1'b1;
        r.want  = '{k, (k == KIND_END) ? 8'h00 : c, 1'b1, ln, col, 1'b1};
        script.push_back(r);
    endfunction

    function automatic void put_cfg(input logic [0:0] idx, input logic v);
        script_row_t r;
        r.op    = ROW_CFG;
        r.idx   = idx;
        r.val   = v;
        r.ch    = 8'h00;
        r.fixed = 1'b0;
        r.want  = '0;
        script.push_back(r);
    endfunction

    task automatic send_byte(input logic [7:0] c);
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scan_byte(c);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic v);
        wait_drained();
        // a held byte gives no result, let it settle
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WS_TOKENS)
            ws_mode = v;
        else
            blk_mode = v;
    endtask

    task automatic send_document(input int len, input logic terminate);
        int unsigned pick;
        logic        noise;
        noise = ($urandom_range(4) == 0);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (noise)
                send_byte(8'($urandom_range(255)));
            else if (pick < 30)
                send_byte(8'($urandom_range(8'h41, 8'h7A)));
            else if (pick < 45)
            begin
                send_byte(CH_OPEN);
                send_byte(CH_OPEN);
            end
            else if (pick < 60)
            begin
                send_byte(CH_CLOSE);
                send_byte(CH_CLOSE);
            end
            else if (pick < 68)
                send_byte($urandom_range(1) ? CH_OPEN : CH_CLOSE);
            else if (pick < 76)
                send_byte($urandom_range(1) ? CH_HASH : CH_SLASH);
            else if (pick < 88)
                send_byte($urandom_range(5) == 0 ? 8'h20 : 8'($urandom_range(8'h09, 8'h0D)));
            else if (pick < 95)
                send_byte(CH_NL);
            else
                send_byte(8'($urandom_range(1, 255)));
        end
        if (terminate)
            send_byte(CH_NUL);
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_token();
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 7);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("template_token_scanner_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic ws_pick;
        logic blk_pick;
        reset_scanner_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_typed(CH_NUL, KIND_END, 16'd1, 16'd0);
        put_byte(8'h61);
        put_byte(CH_OPEN);
        put_typed(CH_OPEN, KIND_OPEN, 16'd1, 16'd1);
        put_byte(CH_CLOSE);
        put_typed(CH_CLOSE, KIND_CLOSE, 16'd1, 16'd3);
        put_byte(8'hFF);
        put_byte(CH_HASH);
        put_byte(CH_SLASH);
        put_byte(8'h20);
        put_byte(CH_NL);
        put_byte(CH_OPEN);
        put_byte(CH_CLOSE);
        put_byte(CH_NUL);
        put_cfg(CFG_WS_TOKENS, 1'b1);
        put_cfg(CFG_BLOCK_TOKENS, 1'b1);
        put_byte(8'h09);
        put_byte(8'h20);
        put_byte(8'h0D);
        put_byte(CH_HASH);
        put_byte(CH_SLASH);
        put_byte(CH_OPEN);
        put_byte(CH_OPEN);
        put_byte(8'h0B);
        // mode change while a byte is held back
        put_cfg(CFG_WS_TOKENS, 1'b0);
        put_byte(CH_HASH);
        put_cfg(CFG_BLOCK_TOKENS, 1'b0);
        put_byte(CH_NUL);

        foreach (script[i])
        begin
            if (script[i].op == ROW_CFG)
            begin
                write_reg(script[i].idx, script[i].val);
            end
            else
            begin
                send_byte(script[i].ch);
                if (script[i].fixed)
                begin
                    void'(pending_tokens.pop_back());
                    pending_tokens.push_back(script[i].want);
                end
            end
        end

        for (int p = 0; p < 12; p++)
        begin
            ws_pick  = (p < 4) ? p[0] : 1'($urandom_range(1));
            blk_pick = (p < 4) ? p[1] : 1'($urandom_range(1));
            write_reg(CFG_WS_TOKENS, ws_pick);
            write_reg(CFG_BLOCK_TOKENS, blk_pick);
            if (p == 2)
                hold_req = 1'b1;
            calm = (p == 8);
            for (int d = 0; d < 4; d++)
            begin
                if (p == 6 && d == 2)
                    wait_drained();
                send_document($urandom_range(1, 64), (d < 3) || $urandom_range(1));
            end
            calm = 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("template_token_scanner_tb: clean");
        else
            $display("template_token_scanner_tb: errors");
        $finish;
    end

endmodule
